/* sv/adr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adr_pkg
// shared widths, register indexes and stage payload types of the
// axis dead zone and rescale pipeline
// ----------------------------------------------------------------------------
package adr_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int TDATA_BITS     = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PROD_BITS      = 2 * SAMPLE_BITS;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ZONE_LOW    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ZONE_HIGH   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SMOOTH_MODE = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_LOW    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_HIGH   = 3'd4;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SAMPLE_BITS:0]   wide_t;
    typedef logic [SAMPLE_BITS-1:0]        mag_t;
    typedef logic [PROD_BITS-1:0]          prod_t;

    typedef struct packed {
        sample_t zone_low;
        sample_t zone_high;
        logic    smooth_mode;
        sample_t axis_low;
        sample_t axis_high;
    } cfg_t;

    typedef struct packed {
        logic    bypass;
        logic    neg;
        sample_t bypass_val;
    } side_t;

    typedef struct packed {
        mag_t  limit_mag;
        mag_t  diff_mag;
        mag_t  den_mag;
        side_t side;
    } front_t;

    typedef struct packed {
        prod_t prod;
        mag_t  den_mag;
        side_t side;
    } mul_t;

    typedef struct packed {
        prod_t rem;
        prod_t dsh;
        mag_t  quo;
        side_t side;
    } div_t;

    function automatic mag_t abs_mag(wide_t v);
        wide_t n;
        n = -v;
        return v[SAMPLE_BITS] ? n[SAMPLE_BITS-1:0] : v[SAMPLE_BITS-1:0];
    endfunction

endpackage

/* sv/axis_deadzone_rescale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_deadzone_rescale
// dead zone filter with optional linear rescale for one signed axis
// ----------------------------------------------------------------------------
// stages: zone stage, multiplier, one division cell per quotient bit,
//   output register
// throughput: one request per cycle while m_tready is high; every stage
//   has its own valid and a ready back through the row, so bubbles close up
// reset: all stage valids cleared, config registers load their default values
// ----------------------------------------------------------------------------
module axis_deadzone_rescale
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [adr_pkg::TDATA_BITS-1:0]        s_tdata,   // sample
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [adr_pkg::TDATA_BITS-1:0]        m_tdata,   // filtered
    input  logic                                  cfg_we,
    input  logic [adr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [adr_pkg::SAMPLE_BITS-1:0]       cfg_wdata
);

    localparam int N = adr_pkg::SAMPLE_BITS;

    adr_pkg::sample_t  zone_low_reg;
    adr_pkg::sample_t  zone_high_reg;
    logic              smooth_mode_reg;
    adr_pkg::sample_t  axis_low_reg;
    adr_pkg::sample_t  axis_high_reg;
    adr_pkg::cfg_t     cfg;

    logic              front_valid;
    logic              front_ready;
    adr_pkg::front_t   front_data;
    logic              mul_valid;
    logic              mul_ready;
    adr_pkg::mul_t     mul_data;

    logic              chain_valid [0:N];
    logic              chain_ready [0:N];
    adr_pkg::div_t     chain_data  [0:N];

    adr_pkg::sample_t  filtered;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_low_reg    <= '0;
            zone_high_reg   <= '0;
            smooth_mode_reg <= 1'b1;
            axis_low_reg    <= {1'b1, {(N-1){1'b0}}};
            axis_high_reg   <= {1'b0, {(N-1){1'b1}}};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                adr_pkg::REG_ZONE_LOW:    zone_low_reg    <= cfg_wdata;
                adr_pkg::REG_ZONE_HIGH:   zone_high_reg   <= cfg_wdata;
                adr_pkg::REG_SMOOTH_MODE: smooth_mode_reg <= cfg_wdata[0];
                adr_pkg::REG_AXIS_LOW:    axis_low_reg    <= cfg_wdata;
                adr_pkg::REG_AXIS_HIGH:   axis_high_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.zone_low    = zone_low_reg;
        cfg.zone_high   = zone_high_reg;
        cfg.smooth_mode = smooth_mode_reg;
        cfg.axis_low    = axis_low_reg;
        cfg.axis_high   = axis_high_reg;
    end

    adr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .sample    (s_tdata[N-1:0]),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    adr_mul u_mul
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_data  (mul_data)
    );

    // first cell tests the divisor at the saturation weight
    assign chain_valid[0] = mul_valid;
    assign mul_ready      = chain_ready[0];
    assign chain_data[0]  = {mul_data.prod,
                             {1'b0, mul_data.den_mag, {(N-1){1'b0}}},
                             adr_pkg::mag_t'(0),
                             mul_data.side};

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            adr_div_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (chain_valid[i]),
                .in_ready  (chain_ready[i]),
                .in_data   (chain_data[i]),
                .out_valid (chain_valid[i+1]),
                .out_ready (chain_ready[i+1]),
                .out_data  (chain_data[i+1])
            );
        end
    endgenerate

    adr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[N]),
        .in_ready  (chain_ready[N]),
        .in_data   (chain_data[N]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (filtered)
    );

    always_comb
    begin
        m_tdata        = '0;
        m_tdata[N-1:0] = filtered;
    end

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

endmodule

/* sv/adr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adr_front
// zone decision, branch operands and magnitudes, one register stage
// ----------------------------------------------------------------------------
module adr_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  adr_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  adr_pkg::sample_t     sample,
    output logic                 out_valid,
    input  logic                 out_ready,
    output adr_pkg::front_t      out_data
);

    logic             valid_reg;
    adr_pkg::front_t  data_reg;
    adr_pkg::front_t  data_next;
    logic             below;
    logic             above;
    adr_pkg::wide_t   limit_x;
    adr_pkg::wide_t   edge_x;
    adr_pkg::wide_t   diff_x;
    adr_pkg::wide_t   den_x;

    assign below = sample < cfg.zone_low;
    assign above = sample > cfg.zone_high;

    always_comb
    begin
        limit_x = below ? adr_pkg::wide_t'(cfg.axis_low) : adr_pkg::wide_t'(cfg.axis_high);
        edge_x  = below ? adr_pkg::wide_t'(cfg.zone_low) : adr_pkg::wide_t'(cfg.zone_high);
        diff_x  = adr_pkg::wide_t'(sample) - edge_x;
        den_x   = limit_x - edge_x;

        data_next.limit_mag = adr_pkg::abs_mag(limit_x);
        data_next.diff_mag  = adr_pkg::abs_mag(diff_x);
        data_next.den_mag   = adr_pkg::abs_mag(den_x);
        data_next.side.neg  = (limit_x[adr_pkg::SAMPLE_BITS] ^ diff_x[adr_pkg::SAMPLE_BITS]
                               ^ den_x[adr_pkg::SAMPLE_BITS])
                              && (limit_x != '0) && (diff_x != '0);

        if (!cfg.smooth_mode)
        begin
            data_next.side.bypass     = 1'b1;
            data_next.side.bypass_val = (below || above) ? sample : '0;
        end
        else if (!below && !above)
        begin
            data_next.side.bypass     = 1'b1;
            data_next.side.bypass_val = '0;
        end
        else if (den_x == '0)
        begin
            // zero span: result is the axis limit
            data_next.side.bypass     = 1'b1;
            data_next.side.bypass_val = limit_x[adr_pkg::SAMPLE_BITS-1:0];
        end
        else
        begin
            data_next.side.bypass     = 1'b0;
            data_next.side.bypass_val = '0;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    a_hard_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !cfg.smooth_mode && !below && !above
        |=> out_valid && out_data.side.bypass && (out_data.side.bypass_val == '0))
        else $error("hard mode sample inside zone not forced to zero");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.side.bypass |-> out_data.den_mag != '0)
        else $error("division request with zero span");

endmodule

/* sv/adr_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adr_mul
// magnitude product of axis limit and zone offset, one register stage
// ----------------------------------------------------------------------------
module adr_mul
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  adr_pkg::front_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output adr_pkg::mul_t     out_data
);

    logic           valid_reg;
    adr_pkg::mul_t  data_reg;
    adr_pkg::mul_t  data_next;

    always_comb
    begin
        data_next.prod    = adr_pkg::prod_t'(in_data.limit_mag) * adr_pkg::prod_t'(in_data.diff_mag);
        data_next.den_mag = in_data.den_mag;
        data_next.side    = in_data.side;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* sv/adr_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adr_div_cell
// one restoring division step: one quotient bit, divisor shifted for the
// next cell
// ----------------------------------------------------------------------------
module adr_div_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  adr_pkg::div_t     in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output adr_pkg::div_t     out_data
);

    logic           valid_reg;
    adr_pkg::div_t  data_reg;
    adr_pkg::div_t  data_next;
    logic           ge;

    assign ge = in_data.rem >= in_data.dsh;

    always_comb
    begin
        data_next.rem  = ge ? (in_data.rem - in_data.dsh) : in_data.rem;
        data_next.dsh  = in_data.dsh >> 1;
        data_next.quo  = {in_data.quo[adr_pkg::SAMPLE_BITS-2:0], ge};
        data_next.side = in_data.side;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* sv/adr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adr_back
// sign, saturation and bypass selection into the output register
// ----------------------------------------------------------------------------
module adr_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  adr_pkg::div_t     in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output adr_pkg::sample_t  out_data
);

    logic              valid_reg;
    adr_pkg::sample_t  data_reg;
    adr_pkg::sample_t  data_next;
    adr_pkg::sample_t  qm;
    logic              sat;

    // top quotient bit set means the quotient reached the sample range limit
    assign sat = in_data.quo[adr_pkg::SAMPLE_BITS-1];
    assign qm  = adr_pkg::sample_t'({1'b0, in_data.quo[adr_pkg::SAMPLE_BITS-2:0]});

    always_comb
    begin
        if (in_data.side.bypass)
        begin
            data_next = in_data.side.bypass_val;
        end
        else if (sat)
        begin
            data_next = in_data.side.neg ? {1'b1, {(adr_pkg::SAMPLE_BITS-1){1'b0}}}
                                         : {1'b0, {(adr_pkg::SAMPLE_BITS-1){1'b1}}};
        end
        else
        begin
            data_next = in_data.side.neg ? -qm : qm;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule
